[sv/lbfw_pkg.sv]
// Package for the LED bitplane frame writer.
// Holds field widths, command codes, sequencer states and default sizes.
// No dependencies; the interfaces and the top level refer to it by scoped names.
package lbfw_pkg;

  localparam int unsigned CmdW         = 2;
  localparam int unsigned StripW       = 4;
  localparam int unsigned ColumnW      = 6;
  localparam int unsigned CountW       = 7;
  localparam int unsigned ColorW       = 8;
  localparam int unsigned WordIdxW     = 11;
  localparam int unsigned ReadWordW    = 16;
  localparam int unsigned BitsPerPixel = 3 * ColorW;
  localparam int unsigned BitCntW      = 5;

  localparam int unsigned DefColumns   = 64;
  localparam int unsigned DefLanes     = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_SET  = 2'd0,
    CMD_FILL = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_WR,
    S_RADR,
    S_RDAT
  } state_e;

endpackage

[sv/lbfw_cmd_if.sv]
// Command channel of the LED bitplane frame writer: valid/ready plus one command word.
// Depends on lbfw_pkg for field widths.
interface lbfw_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [lbfw_pkg::CmdW-1:0]         cmd;
  logic [lbfw_pkg::StripW-1:0]       strip;
  logic [lbfw_pkg::ColumnW-1:0]      column;
  logic [lbfw_pkg::CountW-1:0]       count;
  logic [lbfw_pkg::ColorW-1:0]       red;
  logic [lbfw_pkg::ColorW-1:0]       green;
  logic [lbfw_pkg::ColorW-1:0]       blue;
  logic [lbfw_pkg::WordIdxW-1:0]     word_index;

  modport source (
    output valid, cmd, strip, column, count, red, green, blue, word_index,
    input  ready
  );
  modport sink (
    input  valid, cmd, strip, column, count, red, green, blue, word_index,
    output ready
  );
endinterface

[sv/lbfw_rsp_if.sv]
// Response channel of the LED bitplane frame writer: valid/ready plus one result word.
// Depends on lbfw_pkg for field widths.
interface lbfw_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [lbfw_pkg::ReadWordW-1:0]    read_word;
  logic                              is_read;

  modport source (
    output valid, read_word, is_read,
    input  ready
  );
  modport sink (
    input  valid, read_word, is_read,
    output ready
  );
endinterface

[sv/lbfw_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module lbfw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/led_bitplane_frame_writer_unit.sv]
// Top level of the LED bitplane frame writer: sequencer, color shifter and frame RAM.
// Depends on lbfw_pkg, lbfw_cmd_if, lbfw_rsp_if and lbfw_ram.
//
// The frame RAM holds COLUMNS*24 words of LANES bits; bit s of a word belongs to strip s,
// and each column owns 24 consecutive words (green, red, blue, MSB first). After reset the
// block clears all COLUMNS*24 words (1536 at the defaults), one word per cycle, with cmd
// ready low. Every command returns one response word. Pixel writes are read-modify-write
// on the RAM's shared read/write address: each word is read in S_RD and written back in
// S_WR with only the strip's bit changed. A read passes S_RADR, then S_RDAT takes the RAM
// data. Rejected commands (bad strip, bad column, zero count, read index out of range,
// unused code) are acknowledged in the next cycle. A new command is taken once the
// previous one is finished and its response has left or is leaving the output register.
module led_bitplane_frame_writer_unit #(
  parameter int unsigned COLUMNS = lbfw_pkg::DefColumns,
  parameter int unsigned LANES   = lbfw_pkg::DefLanes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lbfw_cmd_if.sink          cmd_i,
  lbfw_rsp_if.source        rsp_o
);

  localparam int unsigned Words = COLUMNS * lbfw_pkg::BitsPerPixel;
  localparam int unsigned AddrW = $clog2(Words);
  localparam int unsigned CntW  = lbfw_pkg::CountW;
  localparam int unsigned BitW  = lbfw_pkg::BitCntW;
  localparam int unsigned ColW  = lbfw_pkg::BitsPerPixel;

  lbfw_pkg::state_e state_q, state_d;

  logic [AddrW-1:0]                  addr_q, addr_d;
  logic [BitW-1:0]                   bit_q, bit_d;
  logic [CntW-1:0]                   pix_q, pix_d;
  logic [CntW-1:0]                   limit_q, limit_d;
  logic [ColW-1:0]                   col_q, col_d;
  logic [lbfw_pkg::StripW-1:0]       strip_q, strip_d;
  logic                              rsp_valid_q, rsp_valid_d;
  logic [lbfw_pkg::ReadWordW-1:0]    rsp_word_q, rsp_word_d;
  logic                              rsp_is_read_q, rsp_is_read_d;

  logic                              out_free;
  logic                              accept;
  logic                              strip_ok;
  logic [CntW-1:0]                   fill_n;
  logic [LANES-1:0]                  mask;

  logic                              ram_we;
  logic [LANES-1:0]                  ram_wdata;
  logic [LANES-1:0]                  ram_rdata;

  lbfw_ram #(
    .Width (LANES),
    .Depth (Words)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign out_free     = !rsp_valid_q || rsp_o.ready;
  assign cmd_i.ready  = (state_q == lbfw_pkg::S_IDLE) && out_free;
  assign accept       = cmd_i.valid && cmd_i.ready;
  assign strip_ok     = 32'(cmd_i.strip) < LANES;
  assign fill_n       = (32'(cmd_i.count) > COLUMNS) ? CntW'(COLUMNS) : cmd_i.count;
  assign mask         = LANES'(1) << strip_q;

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_word = rsp_word_q;
  assign rsp_o.is_read   = rsp_is_read_q;

  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    bit_d         = bit_q;
    pix_d         = pix_q;
    limit_d       = limit_q;
    col_d         = col_q;
    strip_d       = strip_q;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    rsp_word_d    = rsp_word_q;
    rsp_is_read_d = rsp_is_read_q;
    ram_we        = 1'b0;
    ram_wdata     = (ram_rdata & ~mask) | (col_q[ColW-1] ? mask : '0);

    unique case (state_q)
      lbfw_pkg::S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (addr_q == AddrW'(Words - 1)) begin
          addr_d  = '0;
          state_d = lbfw_pkg::S_IDLE;
        end else begin
          addr_d = addr_q + AddrW'(1);
        end
      end
      lbfw_pkg::S_IDLE: begin
        if (accept) begin
          strip_d       = cmd_i.strip;
          col_d         = {cmd_i.green, cmd_i.red, cmd_i.blue};
          rsp_word_d    = '0;
          rsp_is_read_d = 1'b0;
          unique case (lbfw_pkg::cmd_e'(cmd_i.cmd))
            lbfw_pkg::CMD_SET: begin
              if (strip_ok && 32'(cmd_i.column) < COLUMNS) begin
                addr_d  = AddrW'(32'(cmd_i.column) * lbfw_pkg::BitsPerPixel);
                limit_d = CntW'(1);
                state_d = lbfw_pkg::S_RD;
              end else begin
                rsp_valid_d = 1'b1;
              end
            end
            lbfw_pkg::CMD_FILL: begin
              if (strip_ok && fill_n != '0) begin
                addr_d  = '0;
                limit_d = fill_n;
                state_d = lbfw_pkg::S_RD;
              end else begin
                rsp_valid_d = 1'b1;
              end
            end
            lbfw_pkg::CMD_READ: begin
              if (32'(cmd_i.word_index) < Words) begin
                addr_d  = AddrW'(cmd_i.word_index);
                state_d = lbfw_pkg::S_RADR;
              end else begin
                rsp_valid_d   = 1'b1;
                rsp_is_read_d = 1'b1;
              end
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end
      lbfw_pkg::S_RD: begin
        state_d = lbfw_pkg::S_WR;
      end
      lbfw_pkg::S_WR: begin
        ram_we  = 1'b1;
        col_d   = {col_q[ColW-2:0], col_q[ColW-1]};
        addr_d  = addr_q + AddrW'(1);
        state_d = lbfw_pkg::S_RD;
        if (bit_q == BitW'(lbfw_pkg::BitsPerPixel - 1)) begin
          bit_d = '0;
          if (pix_q == limit_q - CntW'(1)) begin
            pix_d         = '0;
            addr_d        = '0;
            rsp_valid_d   = 1'b1;
            rsp_word_d    = '0;
            rsp_is_read_d = 1'b0;
            state_d       = lbfw_pkg::S_IDLE;
          end else begin
            pix_d = pix_q + CntW'(1);
          end
        end else begin
          bit_d = bit_q + BitW'(1);
        end
      end
      lbfw_pkg::S_RADR: begin
        state_d = lbfw_pkg::S_RDAT;
      end
      lbfw_pkg::S_RDAT: begin
        rsp_valid_d   = 1'b1;
        rsp_word_d    = lbfw_pkg::ReadWordW'(ram_rdata);
        rsp_is_read_d = 1'b1;
        addr_d        = '0;
        state_d       = lbfw_pkg::S_IDLE;
      end
      default: begin
        state_d = lbfw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbfw_pkg::S_CLR;
      addr_q      <= '0;
      bit_q       <= '0;
      pix_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      bit_q       <= bit_d;
      pix_q       <= pix_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q       <= limit_d;
    col_q         <= col_d;
    strip_q       <= strip_d;
    rsp_word_q    <= rsp_word_d;
    rsp_is_read_q <= rsp_is_read_d;
  end

`ifndef SYNTH
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ready |-> state_q == lbfw_pkg::S_IDLE)
    else $error("cmd ready outside idle");

  a_we_only_clr_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == lbfw_pkg::S_CLR || state_q == lbfw_pkg::S_WR))
    else $error("RAM write outside clear or write step");

  a_idle_counters_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lbfw_pkg::S_IDLE |-> (bit_q == '0 && pix_q == '0))
    else $error("sequencer counters not zero in idle");

  a_read_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(rsp_valid_q) && rsp_is_read_q && rsp_word_q != '0)
      |-> $past(state_q) == lbfw_pkg::S_RDAT)
    else $error("read data response without RAM read");

  a_bit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lbfw_pkg::S_WR |-> 32'(bit_q) < lbfw_pkg::BitsPerPixel)
    else $error("bit counter past pixel end");
`endif

endmodule
